### rtl/spba_pkg.sv
// shared types and constants for the slab page bitmap allocator
// used by spba_map_mem and slab_page_bitmap_allocator; no dependencies
`default_nettype none

package spba_pkg;

   localparam int unsigned SLAB_PAGE_COUNT = 16384;
   localparam int unsigned MAX_RUN_PAGES   = 256;
   localparam int unsigned MAP_WORD_BITS   = 64;
   localparam int unsigned MAP_WORDS       = SLAB_PAGE_COUNT / MAP_WORD_BITS;
   localparam int unsigned MAP_ADDR_W      = $clog2(MAP_WORDS);
   localparam int unsigned WORD_BIT_W      = $clog2(MAP_WORD_BITS);
   localparam int unsigned PAGE_W          = 14;
   localparam int unsigned COUNT_W         = 9;
   localparam int unsigned ALIGN_W         = 5;
   localparam int unsigned LIVE_W          = 11;
   localparam int unsigned LIVE_MAX        = 2047;
   localparam int unsigned MIN_ALIGN_LOG2  = 16;
   localparam int unsigned PAGE_LOG2       = 12;
   // wide enough for a candidate start past the slab at the largest step
   localparam int unsigned CAND_W          = 21;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   typedef struct packed {
      logic                 kind;
      logic [COUNT_W-1:0]   page_count;
      logic [ALIGN_W-1:0]   align_log2;
      logic [PAGE_W-1:0]    free_start_page;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [PAGE_W-1:0]    start_page;
      logic [LIVE_W-1:0]    live_runs;
      logic                 became_empty;
   } rsp_type;

   typedef struct packed {
      logic                     en;
      logic [MAP_ADDR_W-1:0]    addr;
      logic [MAP_WORD_BITS-1:0] data;
   } map_wr_type;

endpackage

`default_nettype wire

### rtl/spba_map_mem.sv
// used-page bitmap: one synchronous ram word per 64 pages, with a valid bit per word
// depends on spba_pkg
`default_nettype none

module spba_map_mem (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              clear_all,
   input  wire spba_pkg::map_wr_type              map_wr,
   input  wire logic [spba_pkg::MAP_ADDR_W-1:0]   rd_addr,
   output logic [spba_pkg::MAP_WORD_BITS-1:0]     rd_data
);
   import spba_pkg::*;

   logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0]     word_valid_ff;
   logic [MAP_WORD_BITS-1:0] rd_word_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (map_wr.en) begin
         map_mem[map_wr.addr] <= map_wr.data;
      end
      rd_word_ff <= map_mem[rd_addr];
   end

   // a word never written since reset or since the slab emptied reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         rd_valid_ff <= word_valid_ff[rd_addr];
         if (clear_all) begin
            word_valid_ff <= '0;
         end else if (map_wr.en) begin
            word_valid_ff[map_wr.addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

### rtl/slab_page_bitmap_allocator.sv
// top level of the slab page bitmap allocator: request sequencer around the bitmap ram
// depends on spba_pkg and spba_map_mem
`default_nettype none

// One transaction is taken when start is high and busy is low; its single result
// appears on rsp_item, marked by rsp_strobe for one cycle, and the receiver cannot
// stall it. A request that fails its up-front checks answers in the cycle after it is
// taken. An allocate walks the bitmap ram one 64-page word per cycle, from page 0
// through every candidate start it tries, then marks the chosen run word by word
// with a read-modify-write, so the search loop over the ram's single read port
// sets the rate. A free checks the run's words and then clears them word by word.
// After reset the bitmap is free at once: per-word valid bits stand in for a
// clearing pass, and the same bits drop together when the last live run is freed.
module slab_page_bitmap_allocator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire spba_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output spba_pkg::rsp_type      rsp_item
);
   import spba_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_MARK
   } state_type;

   function automatic logic [WORD_BIT_W-1:0] first_set(input logic [MAP_WORD_BITS-1:0] bits);
      logic [WORD_BIT_W-1:0] idx;
      idx = '0;
      for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
         if (bits[b]) begin
            idx = WORD_BIT_W'(b);
         end
      end
      return idx;
   endfunction

   state_type           state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ALIGN_W-1:0]  shift_ff, shift_in;
   logic [PAGE_W-1:0]   cand_ff, cand_in;
   logic [PAGE_W-1:0]   end_ff, end_in;
   logic [PAGE_W-1:0]   ptr_ff, ptr_in;
   logic [LIVE_W-1:0]   live_ff, live_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_ff, rsp_in;

   map_wr_type               map_wr;
   logic                     clear_all;
   logic [MAP_ADDR_W-1:0]    rd_addr;
   logic [MAP_WORD_BITS-1:0] rd_data;

   logic [MAP_ADDR_W-1:0]    word_idx;
   logic                     last_word;
   logic [WORD_BIT_W-1:0]    hi_bit;
   logic [MAP_WORD_BITS-1:0] range_mask;
   logic [MAP_WORD_BITS-1:0] used_bits;
   logic [MAP_WORD_BITS-1:0] hole_bits;
   logic [PAGE_W-1:0]        hit_page;
   logic [CAND_W-1:0]        step_mask;
   logic [CAND_W-1:0]        next_cand;
   logic                     next_fits;
   logic [PAGE_W-1:0]        next_end;
   logic [PAGE_W-1:0]        next_word_ptr;
   logic                     alloc_reject;
   logic                     free_reject;
   logic [PAGE_W:0]          free_sum;
   logic [ALIGN_W-1:0]       req_shift;

   spba_map_mem u_map_mem (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .map_wr    (map_wr),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // page range of the current word that belongs to the run being looked at
   always_comb begin
      word_idx   = ptr_ff[PAGE_W-1:WORD_BIT_W];
      last_word  = word_idx == end_ff[PAGE_W-1:WORD_BIT_W];
      hi_bit     = last_word ? end_ff[WORD_BIT_W-1:0] : WORD_BIT_W'(MAP_WORD_BITS - 1);
      range_mask = ({MAP_WORD_BITS{1'b1}} << ptr_ff[WORD_BIT_W-1:0])
                 & ({MAP_WORD_BITS{1'b1}} >> (WORD_BIT_W'(MAP_WORD_BITS - 1) - hi_bit));
      used_bits  = rd_data & range_mask;
      hole_bits  = ~rd_data & range_mask;
      hit_page   = {word_idx, first_set(used_bits)};
      // next aligned start strictly after the first used page
      step_mask  = (CAND_W'(1) << shift_ff) - CAND_W'(1);
      next_cand  = (CAND_W'(hit_page) | step_mask) + CAND_W'(1);
      next_fits  = ((CAND_W + 1)'(next_cand) + (CAND_W + 1)'(count_ff))
                   <= (CAND_W + 1)'(SLAB_PAGE_COUNT);
      next_end   = PAGE_W'(next_cand + CAND_W'(count_ff) - CAND_W'(1));
      next_word_ptr = {word_idx + MAP_ADDR_W'(1), WORD_BIT_W'(0)};
   end

   always_comb begin
      alloc_reject = req_item.page_count == '0
                  || req_item.page_count > COUNT_W'(MAX_RUN_PAGES)
                  || live_ff >= LIVE_W'(LIVE_MAX);
      free_sum     = (PAGE_W + 1)'(req_item.free_start_page)
                   + (PAGE_W + 1)'(req_item.page_count);
      free_reject  = req_item.page_count == '0
                  || req_item.page_count > COUNT_W'(MAX_RUN_PAGES)
                  || live_ff == '0
                  || free_sum > (PAGE_W + 1)'(SLAB_PAGE_COUNT);
      if (req_item.align_log2 < ALIGN_W'(MIN_ALIGN_LOG2)) begin
         req_shift = ALIGN_W'(MIN_ALIGN_LOG2 - PAGE_LOG2);
      end else begin
         req_shift = req_item.align_log2 - ALIGN_W'(PAGE_LOG2);
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      count_in      = count_ff;
      shift_in      = shift_ff;
      cand_in       = cand_ff;
      end_in        = end_ff;
      ptr_in        = ptr_ff;
      live_in       = live_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr       = word_idx;
      map_wr.en     = 1'b0;
      map_wr.addr   = word_idx;
      map_wr.data   = (kind_ff == KIND_ALLOC) ? (rd_data | range_mask)
                                              : (rd_data & ~range_mask);
      clear_all     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_item.kind;
               count_in = req_item.page_count;
               shift_in = req_shift;
               if (req_item.kind == KIND_ALLOC) begin
                  if (alloc_reject) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = '{status: STATUS_NO_SPACE, start_page: '0,
                                live_runs: live_ff, became_empty: 1'b0};
                  end else begin
                     cand_in  = '0;
                     ptr_in   = '0;
                     end_in   = PAGE_W'(req_item.page_count) - PAGE_W'(1);
                     rd_addr  = '0;
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (free_reject) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = '{status: STATUS_BAD_FREE, start_page: '0,
                                live_runs: live_ff, became_empty: 1'b0};
                  end else begin
                     cand_in  = req_item.free_start_page;
                     ptr_in   = req_item.free_start_page;
                     end_in   = PAGE_W'(free_sum - (PAGE_W + 1)'(1));
                     rd_addr  = req_item.free_start_page[PAGE_W-1:WORD_BIT_W];
                     state_in = ST_CHECK;
                  end
               end
            end
         end

         ST_SCAN: begin
            if (used_bits != '0) begin
               if (next_fits) begin
                  cand_in = PAGE_W'(next_cand);
                  ptr_in  = PAGE_W'(next_cand);
                  end_in  = next_end;
                  rd_addr = next_cand[PAGE_W-1:WORD_BIT_W];
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{status: STATUS_NO_SPACE, start_page: '0,
                             live_runs: live_ff, became_empty: 1'b0};
                  state_in = ST_IDLE;
               end
            end else if (last_word) begin
               ptr_in   = cand_ff;
               rd_addr  = cand_ff[PAGE_W-1:WORD_BIT_W];
               state_in = ST_MARK;
            end else begin
               ptr_in  = next_word_ptr;
               rd_addr = next_word_ptr[PAGE_W-1:WORD_BIT_W];
            end
         end

         ST_CHECK: begin
            if (hole_bits != '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in = '{status: STATUS_BAD_FREE, start_page: '0,
                          live_runs: live_ff, became_empty: 1'b0};
               state_in = ST_IDLE;
            end else if (last_word) begin
               ptr_in   = cand_ff;
               rd_addr  = cand_ff[PAGE_W-1:WORD_BIT_W];
               state_in = ST_MARK;
            end else begin
               ptr_in  = next_word_ptr;
               rd_addr = next_word_ptr[PAGE_W-1:WORD_BIT_W];
            end
         end

         ST_MARK: begin
            // read-modify-write; the next word is read while this one is written
            map_wr.en = 1'b1;
            if (last_word) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               if (kind_ff == KIND_ALLOC) begin
                  live_in = live_ff + LIVE_W'(1);
                  rsp_in  = '{status: STATUS_DONE, start_page: cand_ff,
                              live_runs: live_ff + LIVE_W'(1), became_empty: 1'b0};
               end else begin
                  live_in   = live_ff - LIVE_W'(1);
                  clear_all = live_ff == LIVE_W'(1);
                  rsp_in    = '{status: STATUS_DONE, start_page: '0,
                                live_runs: live_ff - LIVE_W'(1),
                                became_empty: live_ff == LIVE_W'(1)};
               end
            end else begin
               ptr_in  = next_word_ptr;
               rd_addr = next_word_ptr[PAGE_W-1:WORD_BIT_W];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         live_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         rsp_strobe_ff <= rsp_strobe_in;
         kind_ff       <= kind_in;
         count_ff      <= count_in;
         shift_ff      <= shift_in;
         cand_ff       <= cand_in;
         end_ff        <= end_in;
         ptr_ff        <= ptr_in;
         rsp_ff        <= rsp_in;
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // a taken transaction either answers right away or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted transaction neither answered nor in progress");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.became_empty |-> rsp_item.live_runs == '0)
      else $error("slab reported empty with live runs");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status != STATUS_DONE
         |-> rsp_item.start_page == '0 && !rsp_item.became_empty)
      else $error("failed transaction carries a start page or empty flag");

   a_live_with_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && live_ff != $past(live_ff) |-> rsp_strobe && rsp_item.live_runs == live_ff)
      else $error("live run count moved without a matching result");

endmodule

`default_nettype wire

### dv/testbench.sv
// self-checking testbench for slab_page_bitmap_allocator: directed, random and run-count-limit
// transactions checked against an in-bench bitmap predictor; depends on spba_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
   import spba_pkg::*;

   typedef struct {
      int unsigned first;
      int unsigned pages;
   } page_run_type;

   // rounds of sixteen 16-page allocations and one 256-page free, each nets +15 live runs
   localparam int unsigned FILL_ROUNDS  = 136;
   localparam int unsigned FILL_TOP_UP  = LIVE_MAX - 15 * FILL_ROUNDS;
   localparam int unsigned RANDOM_ITEMS = 1000;
   localparam int unsigned BATCH_ITEMS  = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   req_type      pending_requests[$];
   rsp_type      expected_results[$];
   page_run_type live_extents[$];

   // predicted allocator state
   bit          page_used [SLAB_PAGE_COUNT];
   int unsigned live_count = 0;

   int unsigned sender_idle_pct = 28;
   int unsigned fail_count = 0;
   int unsigned n_taken = 0, n_alloc_ok = 0, n_no_space = 0, n_count_full = 0;
   int unsigned n_free_ok = 0, n_bad_free = 0, n_emptied = 0;

   slab_page_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic predict_allocator_result(input req_type txn);
      rsp_type     want;
      int unsigned pages, first, cand, p, shift, step;
      bit          found, clean;
      pages = txn.page_count;
      want  = '0;
      want.status = STATUS_DONE;
      if (txn.kind == KIND_ALLOC) begin
         if (pages == 0 || pages > MAX_RUN_PAGES || live_count >= LIVE_MAX) begin
            want.status = STATUS_NO_SPACE;
            if (pages != 0 && pages <= MAX_RUN_PAGES) n_count_full++;
         end else begin
            shift = (txn.align_log2 < MIN_ALIGN_LOG2) ? MIN_ALIGN_LOG2 : txn.align_log2;
            step  = 1 << (shift - PAGE_LOG2);
            cand  = 0;
            found = 1'b0;
            // first fit, jumping past the first used page to the next aligned start
            while (!found && cand + pages <= SLAB_PAGE_COUNT) begin
               p = cand;
               while (p < cand + pages && !page_used[p]) p++;
               if (p == cand + pages) found = 1'b1;
               else cand = (p + step) & ~(step - 1);
            end
            if (found) begin
               for (p = cand; p < cand + pages; p++) page_used[p] = 1'b1;
               live_count++;
               want.start_page = PAGE_W'(cand);
               live_extents.push_back('{first: cand, pages: pages});
               n_alloc_ok++;
            end else begin
               want.status = STATUS_NO_SPACE;
            end
         end
         if (want.status == STATUS_NO_SPACE) n_no_space++;
      end else begin
         first = txn.free_start_page;
         clean = pages != 0 && pages <= MAX_RUN_PAGES && live_count != 0 &&
                 first + pages <= SLAB_PAGE_COUNT;
         for (p = first; clean && p < first + pages; p++)
            if (!page_used[p]) clean = 1'b0;
         if (!clean) begin
            want.status = STATUS_BAD_FREE;
            n_bad_free++;
         end else begin
            for (p = first; p < first + pages; p++) page_used[p] = 1'b0;
            live_count--;
            n_free_ok++;
            foreach (live_extents[i])
               if (live_extents[i].first == first && live_extents[i].pages == pages) begin
                  live_extents.delete(i);
                  break;
               end
            // last live run gone: the whole slab is handed back, orphans included
            if (live_count == 0) begin
               page_used = '{default: 1'b0};
               live_extents.delete();
               want.became_empty = 1'b1;
               n_emptied++;
            end
         end
      end
      want.live_runs = LIVE_W'(live_count);
      expected_results.push_back(want);
   endtask

   // driver: holds the head transaction on the request port until it is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_allocator_result(req_item);
            void'(pending_requests.pop_front());
            n_taken++;
         end
         if (!start || !busy) begin
            if (pending_requests.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
               start    <= 1'b1;
               req_item <= pending_requests[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_item.status, want.status));
            if (rsp_item.start_page !== want.start_page)
               report_mismatch($sformatf("start_page %0d, expected %0d",
                                         rsp_item.start_page, want.start_page));
            if (rsp_item.live_runs !== want.live_runs)
               report_mismatch($sformatf("live_runs %0d, expected %0d",
                                         rsp_item.live_runs, want.live_runs));
            if (rsp_item.became_empty !== want.became_empty)
               report_mismatch($sformatf("became_empty %0d, expected %0d",
                                         rsp_item.became_empty, want.became_empty));
         end
      end
   end

   task automatic queue_txn(input logic kind, input int unsigned pages,
                            input int unsigned align_l, input int unsigned first);
      req_type txn;
      txn.kind            = kind;
      txn.page_count      = COUNT_W'(pages);
      txn.align_log2      = ALIGN_W'(align_l);
      txn.free_start_page = PAGE_W'(first);
      pending_requests.push_back(txn);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic queue_random_txn();
      int unsigned  roll, pages, align_l, off, len;
      page_run_type ext;
      roll    = $urandom_range(99, 0);
      align_l = ($urandom_range(9, 0) < 7) ? $urandom_range(20, 12) : $urandom_range(31, 0);
      if (live_extents.size() == 0 && roll >= 44 && roll < 86) roll = 0;
      if (roll < 44) begin
         pages = $urandom_range(99, 0);
         if (pages < 70)      pages = $urandom_range(16, 1);
         else if (pages < 90) pages = $urandom_range(64, 17);
         else if (pages < 97) pages = $urandom_range(MAX_RUN_PAGES, 65);
         else                 pages = $urandom_range(511, 0);
         queue_txn(KIND_ALLOC, pages, align_l, $urandom_range(SLAB_PAGE_COUNT - 1, 0));
      end else if (roll < 74) begin
         ext = live_extents[$urandom_range(live_extents.size() - 1, 0)];
         queue_txn(KIND_FREE, ext.pages, align_l, ext.first);
      end else if (roll < 86) begin
         // free a random slice of a live run, which may be the whole run
         ext = live_extents[$urandom_range(live_extents.size() - 1, 0)];
         off = $urandom_range(ext.pages - 1, 0);
         len = $urandom_range(ext.pages - off, 1);
         queue_txn(KIND_FREE, len, align_l, ext.first + off);
      end else begin
         pages = $urandom_range(1, 0) ? $urandom_range(511, 0) : $urandom_range(16, 1);
         off   = $urandom_range(1, 0) ? $urandom_range(SLAB_PAGE_COUNT - 1, 0)
                                      : SLAB_PAGE_COUNT - 1 - $urandom_range(300, 0);
         queue_txn(KIND_FREE, pages, align_l, off);
      end
   endtask

   // frees single used pages until the run count reaches zero
   task automatic drain_slab();
      int unsigned freed;
      while (live_count != 0) begin
         freed = 0;
         for (int p = 0; p < SLAB_PAGE_COUNT && freed < live_count; p++)
            if (page_used[p]) begin
               queue_txn(KIND_FREE, 1, $urandom_range(31, 0), p);
               freed++;
            end
         // more live runs than used pages: park one big run to chip away at
         if (freed == 0) queue_txn(KIND_ALLOC, MAX_RUN_PAGES, PAGE_LOG2, 0);
         wait_drained();
      end
   endtask

   initial begin
      int unsigned n_random;
      page_used = '{default: 1'b0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, count and alignment corner cases
      queue_txn(KIND_ALLOC, 0, PAGE_LOG2, 0);
      queue_txn(KIND_ALLOC, 511, PAGE_LOG2, SLAB_PAGE_COUNT - 1);
      queue_txn(KIND_FREE, 1, 0, 0);
      queue_txn(KIND_ALLOC, MAX_RUN_PAGES, 31, 0);
      queue_txn(KIND_FREE, MAX_RUN_PAGES, 31, 0);
      queue_txn(KIND_ALLOC, 1, 31, 0);
      queue_txn(KIND_ALLOC, 1, 31, 0);
      queue_txn(KIND_ALLOC, 1, 0, 0);
      queue_txn(KIND_ALLOC, MAX_RUN_PAGES, PAGE_LOG2, 0);
      queue_txn(KIND_ALLOC, 17, 20, 0);
      queue_txn(KIND_ALLOC, 3, 17, 0);
      queue_txn(KIND_FREE, 1, 0, 40);
      queue_txn(KIND_FREE, 1, 0, 40);
      queue_txn(KIND_FREE, 2, 0, SLAB_PAGE_COUNT - 1);
      queue_txn(KIND_FREE, 0, 0, 0);
      queue_txn(KIND_FREE, 300, 0, 0);
      queue_txn(KIND_FREE, 511, 31, SLAB_PAGE_COUNT - 1);
      queue_txn(KIND_ALLOC, 16, 15, 0);
      queue_txn(KIND_FREE, 1, 0, 16);
      queue_txn(KIND_FREE, 1, 0, 0);
      queue_txn(KIND_FREE, MAX_RUN_PAGES, 0, 32);
      queue_txn(KIND_ALLOC, MAX_RUN_PAGES, 19, 0);
      wait_drained();

      // random: batches drawn against the runs known to be live
      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         repeat (BATCH_ITEMS) queue_random_txn();
         n_random += BATCH_ITEMS;
         wait_drained();
      end

      drain_slab();

      // back-to-back stretch: climb to the run-count limit and bounce off it
      sender_idle_pct = 0;
      for (int r = 0; r < FILL_ROUNDS; r++) begin
         repeat (16) queue_txn(KIND_ALLOC, 16, $urandom_range(16, 0),
                               $urandom_range(SLAB_PAGE_COUNT - 1, 0));
         queue_txn(KIND_FREE, MAX_RUN_PAGES, $urandom_range(31, 0), 0);
      end
      repeat (FILL_TOP_UP + 2) queue_txn(KIND_ALLOC, 16, PAGE_LOG2, 0);
      queue_txn(KIND_FREE, 16, 0, 0);
      queue_txn(KIND_ALLOC, 16, 16, 0);
      queue_txn(KIND_ALLOC, 1, 31, 0);
      wait_drained();
      sender_idle_pct = 28;

      repeat (300) @(negedge clock);
      $display("%0d transactions: %0d runs placed, %0d allocations refused",
               n_taken, n_alloc_ok, n_no_space);
      $display("%0d of the refusals at the run-count limit", n_count_full);
      $display("%0d frees done, %0d rejected, slab emptied %0d times",
               n_free_ok, n_bad_free, n_emptied);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #500_000_000;
      $display("timeout with %0d transactions pending", pending_requests.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
